// ===== rtl/tlbpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Constants and types shared by the TLB page translation block.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W  = 16;
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int SLOT_W  = $clog2(TLB_ENTRIES);
  localparam int RAW_W   = ADDR_W - OFFSET_BITS;
  localparam int HIT_W   = 32;
  localparam int FAULT_W = 9;

  localparam int S_DATA_W = ((ADDR_W + 7) / 8) * 8;
  localparam int M_FIELD_W = ADDR_W + HIT_W + FAULT_W;
  localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;
  localparam int M_USER_W = 2;

  localparam logic [HIT_W-1:0]   HIT_MAX   = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [SLOT_W-1:0]  slot_t;

endpackage

// ===== rtl/tlb_page_translation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_translation
// Logical to physical address translation through a fully associative TLB
// with LRU replacement, backed by a page table with demand frame allocation.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat contents
// s_       in   tdata: virt_addr[15:0]
// m_       out  tdata: phys_addr, hit_total, fault_total; tuser: hit, fault
//
// Per address: the accept cycle issues the page-table memory read, then
// ST_LOOK does the TLB compare, picks the frame and writes back.
// Next address is taken the cycle after the result is registered.
// A held result stalls ST_LOOK; an address is still taken while
// a finished result waits. Reset clears TLB valid bits, page-table valid
// flip-flops and counters and sets ranks to slot order at once; no clearing pass.
//
module tlb_page_translation (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] virt_addr
  input  logic [tlbpt_pkg::S_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] phys_addr, [47:16] hit_total, [56:48] fault_total, rest zero
  output logic [tlbpt_pkg::M_DATA_W-1:0] m_tdata,
  // [0] tlb_hit, [1] page_fault
  output logic [tlbpt_pkg::M_USER_W-1:0] m_tuser
);
  import tlbpt_pkg::*;

  state_t state;

  // TLB in flip-flops, compared in parallel
  logic                tlb_valid [TLB_ENTRIES];
  page_t               tlb_page  [TLB_ENTRIES];
  frame_t              tlb_frame [TLB_ENTRIES];
  slot_t               tlb_rank  [TLB_ENTRIES];

  // page table: valid flops plus a frame memory
  logic [PAGE_COUNT-1:0] table_valid;
  frame_t              table_mem [PAGE_COUNT];
  frame_t              rd_data;

  frame_t              next_frame;
  logic [HIT_W-1:0]    hit_count;
  logic [FAULT_W-1:0]  fault_count;

  page_t               page_q;
  logic [OFFSET_BITS-1:0] offset_q;

  logic                accept;
  logic                done;
  page_t               page_in;
  logic [RAW_W-1:0]    page_raw;

  logic                hit;
  logic                fault;
  slot_t               hit_slot;
  slot_t               lru_slot;
  slot_t               slot;
  slot_t               slot_rank;
  frame_t              frame;
  logic [HIT_W-1:0]    hit_count_next;
  logic [FAULT_W-1:0]  fault_count_next;
  frame_t              next_frame_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign done     = (state == ST_LOOK) && (!m_tvalid || m_tready);

  assign page_raw = s_tdata[ADDR_W-1:OFFSET_BITS];
  assign page_in  = PAGE_W'(page_raw % PAGE_COUNT);

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    lru_slot = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == page_q) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (tlb_rank[i] == '0) begin
        lru_slot = SLOT_W'(i);
      end
    end
    slot      = hit ? hit_slot : lru_slot;
    slot_rank = tlb_rank[slot];
    fault     = !hit && !table_valid[page_q];
    if (hit) begin
      frame = tlb_frame[hit_slot];
    end else if (fault) begin
      frame = next_frame;
    end else begin
      frame = rd_data;
    end

    hit_count_next = hit_count;
    if (hit && hit_count != HIT_MAX) begin
      hit_count_next = hit_count + 1'b1;
    end
    fault_count_next = fault_count;
    if (fault && fault_count != FAULT_MAX) begin
      fault_count_next = fault_count + 1'b1;
    end
    next_frame_next = (next_frame == '0) ? FRAME_W'(FRAME_COUNT - 1) : next_frame - 1'b1;
  end

  // page-table memory, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= table_mem[page_in];
    end
    if (done && fault) begin
      table_mem[page_q] <= next_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_q   <= page_in;
      offset_q <= s_tdata[OFFSET_BITS-1:0];
    end
    if (done) begin
      m_tdata <= M_DATA_W'({fault_count_next, hit_count_next,
                            ADDR_W'({frame, offset_q})});
      m_tuser <= {fault, hit};
    end
    if (done && !hit) begin
      tlb_page[slot]  <= page_q;
      tlb_frame[slot] <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      table_valid <= '0;
      next_frame  <= FRAME_W'(FRAME_COUNT - 1);
      hit_count   <= '0;
      fault_count <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
        tlb_rank[i]  <= SLOT_W'(i);
      end
    end else begin
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (done) begin
        hit_count   <= hit_count_next;
        fault_count <= fault_count_next;
        // touched entry becomes most recent, younger ones age by one
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_rank[i] > slot_rank) begin
            tlb_rank[i] <= tlb_rank[i] - 1'b1;
          end
        end
        tlb_rank[slot] <= SLOT_W'(TLB_ENTRIES - 1);
        if (!hit) begin
          tlb_valid[slot] <= 1'b1;
        end
        if (fault) begin
          table_valid[page_q] <= 1'b1;
          next_frame          <= next_frame_next;
        end
      end
    end
  end

  // a fault is only ever raised on a TLB miss
  a_fault_not_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("fault and hit flagged on one beat");

  // each page faults at most once
  a_fault_bound: assert property (@(posedge clk) disable iff (rst)
    fault_count <= FAULT_W'(PAGE_COUNT))
    else $error("fault count beyond page count");

  // a hit result moves the hit counter on by one unless saturated
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    done && hit && hit_count != HIT_MAX |=> hit_count == $past(hit_count) + 1'b1)
    else $error("hit counter not advanced");

  // an accepted beat is looked up next cycle, with the input held off
  a_look_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOK && !s_tready)
    else $error("lookup did not follow accept");

endmodule

// ===== tb/tlb_page_translation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_translation_test
// Streams logical addresses into the TLB translation block and checks every
// result beat against a cycle-free predictor of the TLB, LRU ranks, page
// table and counters, under random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tlb_page_translation_test;
  import tlbpt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic               hit;
    logic               fault;
    logic [HIT_W-1:0]   hit_total;
    logic [FAULT_W-1:0] fault_total;
  } translation_t;

  class translation_board;
    logic               slot_ok[TLB_ENTRIES];
    page_t              slot_page[TLB_ENTRIES];
    frame_t             slot_frame[TLB_ENTRIES];
    slot_t              slot_rank[TLB_ENTRIES];
    logic               page_mapped[PAGE_COUNT];
    frame_t             page_frame[PAGE_COUNT];
    frame_t             free_frame;
    logic [HIT_W-1:0]   hits;
    logic [FAULT_W-1:0] faults;
    translation_t       expected_q[$];
    int                 errors;
    int                 beats_seen;

    function new();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        slot_ok[i]   = 1'b0;
        slot_rank[i] = slot_t'(i);
      end
      for (int i = 0; i < PAGE_COUNT; i++) page_mapped[i] = 1'b0;
      free_frame = frame_t'(FRAME_COUNT - 1);
      hits       = '0;
      faults     = '0;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void make_newest(int e);
      slot_t r;
      r = slot_rank[e];
      for (int i = 0; i < TLB_ENTRIES; i++)
        if (slot_rank[i] > r) slot_rank[i] = slot_rank[i] - 1'b1;
      slot_rank[e] = slot_t'(TLB_ENTRIES - 1);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_address(logic [ADDR_W-1:0] addr);
      translation_t t;
      page_t        pg;
      frame_t       fr;
      int unsigned  offs;
      int unsigned  wide;
      int           slot;
      pg   = page_t'((addr >> OFFSET_BITS) % PAGE_COUNT);
      offs = addr & ((1 << OFFSET_BITS) - 1);
      slot = -1;
      t.fault = 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++)
        if (slot == -1 && slot_ok[i] && slot_page[i] == pg) slot = i;
      t.hit = (slot != -1);
      if (t.hit) begin
        fr = slot_frame[slot];
        make_newest(slot);
        if (hits != HIT_MAX) hits = hits + 1'b1;
      end else begin
        if (!page_mapped[pg]) begin
          t.fault         = 1'b1;
          page_mapped[pg] = 1'b1;
          page_frame[pg]  = free_frame;
          free_frame = (free_frame == 0) ? frame_t'(FRAME_COUNT - 1) : free_frame - 1'b1;
          if (faults != FAULT_MAX) faults = faults + 1'b1;
        end
        fr = page_frame[pg];
        // victim is the rank-zero slot
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (slot == -1 && slot_rank[i] == 0) slot = i;
        if (slot == -1) slot = 0;
        slot_ok[slot]    = 1'b1;
        slot_page[slot]  = pg;
        slot_frame[slot] = fr;
        make_newest(slot);
      end
      wide          = (32'(fr) << OFFSET_BITS) + offs;
      t.phys        = wide[ADDR_W-1:0];
      t.hit_total   = hits;
      t.fault_total = faults;
      expected_q.push_back(t);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH beat %0d %s: got %0h, want %0h", beats_seen, what, got, want);
      errors++;
    endtask

    task check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
      translation_t t;
      beats_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected beat", data, 0);
      end else begin
        t = expected_q.pop_front();
        if (data[ADDR_W-1:0] !== t.phys) report("phys_addr", data[ADDR_W-1:0], t.phys);
        if (user[0] !== t.hit) report("tlb_hit", user[0], t.hit);
        if (user[1] !== t.fault) report("page_fault", user[1], t.fault);
        if (data[ADDR_W +: HIT_W] !== t.hit_total)
          report("hit_total", data[ADDR_W +: HIT_W], t.hit_total);
        if (data[ADDR_W+HIT_W +: FAULT_W] !== t.fault_total)
          report("fault_total", data[ADDR_W+HIT_W +: FAULT_W], t.fault_total);
        if (data[M_DATA_W-1:M_FIELD_W] !== '0)
          report("tdata padding", data[M_DATA_W-1:M_FIELD_W], 0);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  translation_board sb;
  bit               rst_done;
  bit               idle_on;
  int               hold_left;
  int               stall_left;
  page_t            last_page;

  tlb_page_translation i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // presents one address and waits for its beat to be taken
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    sb.note_address(addr);
  endtask

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 9));
  endtask

  task automatic drain_wait();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address(input page_t ws_base);
    int    r;
    page_t pg;
    logic [OFFSET_BITS-1:0] offs;
    r = $urandom_range(0, 99);
    if (r < 50) pg = ws_base + page_t'($urandom_range(0, 19));
    else if (r < 60) pg = last_page;
    else pg = page_t'($urandom_range(0, PAGE_COUNT - 1));
    last_page = pg;
    r = $urandom_range(0, 9);
    if (r == 0) offs = '0;
    else if (r == 1) offs = '1;
    else offs = OFFSET_BITS'($urandom);
    return {pg, offs};
  endfunction

  task automatic random_run(input int n, input page_t ws_base);
    repeat (n) begin
      send_address(pick_address(ws_base));
      maybe_gap();
    end
  endtask

  // result side: random stalls, plus a long hold when asked
  initial begin
    logic ready;
    wait (rst_done);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        ready = 1'b0;
      end else begin
        ready = 1'b1;
      end
      m_tready <= ready;
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin
    int order[PAGE_COUNT];
    int j;
    int tmp;
    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    rst_done   = 1'b0;
    idle_on    = 1'b1;
    hold_left  = 0;
    stall_left = 0;
    last_page  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst      <= 1'b0;
    rst_done = 1'b1;

    // directed: extremes, hits, fill of every empty slot, LRU eviction,
    // refill from the page table without a fault
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    for (int p = 1; p < 16; p++) send_address({8'(p), 8'(p * 17)});
    send_address(16'h1001);
    send_address(16'h0080);
    send_address(16'hFF55);
    send_address(16'hAAAA);
    send_address(16'h5555);
    maybe_gap();

    random_run(100, page_t'($urandom));
    idle_on = 1'b0;
    random_run(30, page_t'($urandom));
    idle_on = 1'b1;

    // long hold on the result side while addresses keep coming
    hold_left = 120;
    repeat (12) send_address(pick_address(page_t'($urandom)));
    drain_wait();
    idle_sender($urandom_range(1, 9));

    // every page once in shuffled order, so the frame pool runs down to zero
    for (int i = 0; i < PAGE_COUNT; i++) order[i] = i;
    for (int i = PAGE_COUNT - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < PAGE_COUNT; i++) begin
      send_address({page_t'(order[i]), OFFSET_BITS'($urandom)});
      maybe_gap();
    end
    drain_wait();

    random_run(60, page_t'($urandom));
    idle_on = 1'b0;
    random_run(90, page_t'($urandom));
    idle_sender(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
